// ----- design/tga_rle_pkg.sv -----
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; every other design file refers to it by scoped names.
package tga_rle_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BPP   = 2'd0,
    CFG_RLE   = 2'd1,
    CFG_TOTAL = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers
  localparam logic [2:0]  BPP_RST   = 3'd3;
  localparam logic        RLE_RST   = 1'b0;
  localparam logic [31:0] TOTAL_RST = 32'd1;

  // Pixel sizes in bytes after clamping
  localparam logic [2:0] PIX_MIN = 3'd2;
  localparam logic [2:0] PIX_MAX = 3'd4;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration as seen by the front
  typedef struct packed {
    logic [2:0]  bpp;
    logic        rle;
    logic [31:0] total;
  } cfg_t;

  // One finished pixel request handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  size;
    logic [7:0]  run;
    logic [31:0] start;
    logic        done;
  } pix_cmd_t;

endpackage

// ----- design/tga_rle_front.sv -----
// Front end: accepts stream bytes, parses packet headers, gathers pixel bytes,
// clips runs and keeps the pixel count. Depends on tga_rle_pkg.
module tga_rle_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tga_rle_pkg::cfg_t     cfg,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  output logic                  push,
  output tga_rle_pkg::pix_cmd_t cmd
);

  logic        expect_header_r, expect_header_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [31:0] done_r, done_nxt;

  logic [2:0]  size;
  logic [32:0] diff;
  logic [31:0] remaining;
  logic        complete;
  logic        rem_small;
  logic        is_header;
  logic        gathering;
  logic [31:0] word;
  logic        clip;
  logic [7:0]  run;
  logic        image_done;

  // Clamp the pixel size to 2..4 bytes
  always_comb begin
    if (cfg.bpp < tga_rle_pkg::PIX_MIN) begin
      size = tga_rle_pkg::PIX_MIN;
    end else if (cfg.bpp > tga_rle_pkg::PIX_MAX) begin
      size = tga_rle_pkg::PIX_MAX;
    end else begin
      size = cfg.bpp;
    end
  end

  // Pixels left; a borrow or zero means the image is complete
  assign diff      = {1'b0, cfg.total} - {1'b0, done_r};
  assign remaining = diff[31:0];
  assign complete  = diff[32] || (remaining == 32'd0);
  assign rem_small = (remaining[31:8] == 24'd0);

  assign is_header = cfg.rle && expect_header_r;
  assign gathering = (({1'b0, slot_r} + 3'd1) < size);
  assign word      = {8'd0, gather_r} | ({24'd0, data_byte} << {slot_r, 3'b000});

  // Clip a repeat run to the pixels remaining
  assign clip = rem_small && (remaining[7:0] < packet_left_r);
  always_comb begin
    if (cfg.rle && repeat_r) begin
      run = clip ? remaining[7:0] : packet_left_r;
    end else begin
      run = 8'd1;
    end
  end
  assign image_done = rem_small && (run >= remaining[7:0]);

  // Next stream state and pixel request
  always_comb begin
    expect_header_nxt = expect_header_r;
    repeat_nxt        = repeat_r;
    packet_left_nxt   = packet_left_r;
    slot_nxt          = slot_r;
    gather_nxt        = gather_r;
    done_nxt          = done_r;
    push              = 1'b0;
    cmd.word          = word;
    cmd.size          = size;
    cmd.run           = run;
    cmd.start         = done_r;
    cmd.done          = image_done;
    if (accept && !complete) begin
      if (is_header) begin
        repeat_nxt        = data_byte[7];
        packet_left_nxt   = {1'b0, data_byte[6:0]} + 8'd1;
        expect_header_nxt = 1'b0;
        slot_nxt          = 2'd0;
        gather_nxt        = 24'd0;
      end else if (gathering) begin
        gather_nxt = word[23:0];
        slot_nxt   = slot_r + 2'd1;
      end else begin
        push       = 1'b1;
        gather_nxt = 24'd0;
        slot_nxt   = 2'd0;
        done_nxt   = done_r + {24'd0, run};
        if (cfg.rle) begin
          if (repeat_r) begin
            packet_left_nxt   = 8'd0;
            expect_header_nxt = 1'b1;
          end else begin
            packet_left_nxt = packet_left_r - 8'd1;
            if (packet_left_r == 8'd1) begin
              expect_header_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // Stream state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      repeat_r        <= 1'b0;
      packet_left_r   <= 8'd0;
      slot_r          <= 2'd0;
      gather_r        <= 24'd0;
      done_r          <= 32'd0;
    end else begin
      expect_header_r <= expect_header_nxt;
      repeat_r        <= repeat_nxt;
      packet_left_r   <= packet_left_nxt;
      slot_r          <= slot_nxt;
      gather_r        <= gather_nxt;
      done_r          <= done_nxt;
    end
  end

endmodule

// ----- design/tga_rle_fifo.sv -----
// Short queue of pixel requests between the front and the back.
// Depends on tga_rle_pkg for the request type and depth.
module tga_rle_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tga_rle_pkg::pix_cmd_t push_cmd,
  input  logic                  pop,
  output tga_rle_pkg::pix_cmd_t head,
  output logic                  not_empty,
  output logic                  full
);

  tga_rle_pkg::pix_cmd_t mem_r [tga_rle_pkg::QDEPTH];

  logic [tga_rle_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tga_rle_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tga_rle_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == tga_rle_pkg::QCNT_W'(tga_rle_pkg::QDEPTH));
  assign head      = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tga_rle_pkg::QPTR_W'(tga_rle_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tga_rle_pkg::QPTR_W'(tga_rle_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/tga_rle_back.sv -----
// Back end: expands a gathered pixel word to RGBA and holds the result register.
// Depends on tga_rle_pkg for the request type.
module tga_rle_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  tga_rle_pkg::pix_cmd_t cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [7:0]            out_run_length,
  output logic [31:0]           out_start_index,
  output logic                  out_image_done
);

  logic        valid_r, valid_nxt;
  logic [7:0]  red_r, green_r, blue_r, alpha_r, run_r;
  logic [31:0] start_r;
  logic        done_r;
  logic [7:0]  red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic [7:0]  b0, b1, b2, b3;

  assign b0 = cmd.word[7:0];
  assign b1 = cmd.word[15:8];
  assign b2 = cmd.word[23:16];
  assign b3 = cmd.word[31:24];

  // Expand 5-5-5 with one alpha bit, or take BGR(A) bytes as they are
  always_comb begin
    if (cmd.size == tga_rle_pkg::PIX_MIN) begin
      red_nxt   = {b1[6:2], 3'b000};
      green_nxt = {b1[1:0], b0[7:5], 3'b000};
      blue_nxt  = {b0[4:0], 3'b000};
      alpha_nxt = {b1[7], 7'd0};
    end else begin
      red_nxt   = b2;
      green_nxt = b1;
      blue_nxt  = b0;
      alpha_nxt = (cmd.size == tga_rle_pkg::PIX_MAX) ? b3 : 8'd0;
    end
  end

  // Take the next request when the result register is free or being drained
  assign pop = cmd_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      run_r   <= cmd.run;
      start_r <= cmd.start;
      done_r  <= cmd.done;
    end
  end

  assign out_valid       = valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_run_length  = run_r;
  assign out_start_index = start_r;
  assign out_image_done  = done_r;

endmodule

// ----- design/tga_rle_pixel_decoder_top.sv -----
// TGA pixel decoder top: one stream byte a cycle sustained while the queue is not full; the
// last byte of a pixel is written to the queue, then the result register loads from the
// queue head when it is free or being drained, and offers the result on out_valid.
// The input is held by in_stall while the queue is full.
// Reset (rst_n low, synchronous) restores the registers to 3 bytes, uncompressed,
// one pixel, and empties the queue and result register; no clearing pass.
module tga_rle_pixel_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha,
  output logic [7:0]                         out_run_length,
  output logic [31:0]                        out_start_index,
  output logic                               out_image_done
);

  tga_rle_pkg::cfg_t     cfg_r;
  tga_rle_pkg::pix_cmd_t front_cmd;
  tga_rle_pkg::pix_cmd_t q_head;
  logic                  in_accept;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_empty;
  logic                  q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp   <= tga_rle_pkg::BPP_RST;
      cfg_r.rle   <= tga_rle_pkg::RLE_RST;
      cfg_r.total <= tga_rle_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      unique case (tga_rle_pkg::cfg_idx_t'(cfg_index))
        tga_rle_pkg::CFG_BPP:   cfg_r.bpp   <= cfg_data[2:0];
        tga_rle_pkg::CFG_RLE:   cfg_r.rle   <= cfg_data[0];
        tga_rle_pkg::CFG_TOTAL: cfg_r.total <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Hold the input while the queue is full
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  tga_rle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .push      (q_push),
    .cmd       (front_cmd)
  );

  tga_rle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tga_rle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_not_empty),
    .cmd             (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_run_length  (out_run_length),
    .out_start_index (out_start_index),
    .out_image_done  (out_image_done)
  );

  // A pixel request is only raised for an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_accept)
    else $error("pixel request raised without an accepted byte");

  // The back only drains a non-empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

  // Every delivered run covers at least one pixel and at most a full packet
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length != 8'd0) && (out_run_length <= 8'd128))
    else $error("run length out of range");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for tga_rle_pixel_decoder_top: a directed table, then random
// phases of stream bytes, each checked against a behavioural decoder in this file.
// Depends on tga_rle_pkg for the configuration register indexes and reset values.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int MIN_DECODED = 400;
  localparam int MIN_RESULTS = 48;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run;
    logic [31:0] start;
    logic        done;
  } pixel_res_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    tga_rle_pkg::cfg_idx_t idx;
    logic [31:0]           value;
    logic [7:0]            data;
    bit                    typed;
    pixel_res_t            want;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LONG, STALL_SPARSE} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [7:0]  out_run_length;
  logic [31:0] out_start_index;
  logic        out_image_done;

  // Decoder model: configuration and stream state
  logic [2:0]  cur_bpp;
  logic        cur_rle;
  logic [31:0] cur_total;
  logic        hdr_due;
  logic        pkt_repeat;
  logic [7:0]  pkt_count;
  logic [1:0]  slot;
  logic [23:0] gathered;
  logic [31:0] decoded;

  pixel_res_t  pixels_due[$];
  stim_row_t   directed[$];
  int          mismatches = 0;
  int          results_checked = 0;
  int          bytes_sent = 0;
  int          bytes_decoded = 0;
  int          phases = 0;
  int          cycles = 0;
  int          burst_left = 0;
  logic [7:0]  stall_tick = '0;
  stall_mode_t stall_mode = STALL_NONE;

  tga_rle_pixel_decoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_run_length (out_run_length),
    .out_start_index(out_start_index),
    .out_image_done (out_image_done)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, pixels_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel on a pattern drawn anew at random when the low six bits of stall_tick are zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_LONG:   out_stall <= (stall_tick[3:0] < 4'd11);
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default:      out_stall <= 1'b0;
    endcase
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function automatic pixel_res_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a,
                                            input logic [7:0] run, input logic [31:0] start,
                                            input logic done);
    pixel_res_t px;
    px = '{r, g, b, a, run, start, done};
    return px;
  endfunction

  // Advance the decoder model by one stream byte; flag whether the byte was used
  // and whether it finished a pixel request
  function automatic void decode_byte(input logic [7:0] b, output bit used,
                                      output bit has_px, output pixel_res_t px);
    int unsigned size;
    int unsigned run;
    int unsigned remaining;
    logic [31:0] word;
    logic [31:0] fin;
    used = 1'b0;
    has_px = 1'b0;
    px = '0;
    size = (cur_bpp < 3'd2) ? 2 : (cur_bpp > 3'd4) ? 4 : cur_bpp;
    // Image complete: drop the byte
    if (decoded >= cur_total) return;
    used = 1'b1;
    if (cur_rle && hdr_due) begin
      pkt_repeat = b[7];
      pkt_count = {1'b0, b[6:0]} + 8'd1;
      hdr_due = 1'b0;
      slot = '0;
      gathered = '0;
      return;
    end
    // Gather low bytes until the last byte of the pixel
    if (slot + 1 < size) begin
      gathered = gathered | (24'(b) << (8 * slot));
      slot = slot + 2'd1;
      return;
    end
    word = {8'h00, gathered} | (32'(b) << (8 * slot));
    gathered = '0;
    slot = '0;
    remaining = cur_total - decoded;
    run = 1;
    if (cur_rle && pkt_repeat) begin
      // Clip a repeat run to the pixels left in the image
      run = pkt_count;
      if (run > remaining) run = remaining;
      pkt_count = '0;
      hdr_due = 1'b1;
    end else if (cur_rle) begin
      pkt_count = pkt_count - 8'd1;
      if (pkt_count == 8'd0) hdr_due = 1'b1;
    end
    if (size == 2) begin
      px.red   = {word[14:10], 3'b000};
      px.green = {word[9:5], 3'b000};
      px.blue  = {word[4:0], 3'b000};
      px.alpha = {word[15], 7'b0};
    end else begin
      px.red   = word[23:16];
      px.green = word[15:8];
      px.blue  = word[7:0];
      px.alpha = (size == 4) ? word[31:24] : 8'h00;
    end
    fin = decoded + run;
    px.run = run[7:0];
    px.start = decoded;
    px.done = (fin >= cur_total);
    decoded = fin;
    has_px = 1'b1;
  endfunction

  // Hold the request until accepted, then log what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed, input pixel_res_t want);
    bit used;
    bit has_px;
    pixel_res_t px;
    int gap;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    decode_byte(b, used, has_px, px);
    if (used) bytes_decoded++;
    if (typed) pixels_due.push_back(want);
    else if (has_px) pixels_due.push_back(px);
    // Sender works in bursts with idle gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Let every due result drain, then give the pipeline time to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input tga_rle_pkg::cfg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      tga_rle_pkg::CFG_BPP:   cur_bpp = value[2:0];
      tga_rle_pkg::CFG_RLE:   cur_rle = value[0];
      tga_rle_pkg::CFG_TOTAL: cur_total = value;
      default:   ;
    endcase
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_cfg(input tga_rle_pkg::cfg_idx_t idx, input logic [31:0] value);
    directed.push_back('{ROW_CFG, idx, value, 8'h00, 1'b0, '0});
  endtask

  task automatic add_byte(input logic [7:0] b);
    directed.push_back('{ROW_BYTE, tga_rle_pkg::CFG_BPP, 32'h0, b, 1'b0, '0});
  endtask

  task automatic add_pixel(input logic [7:0] b, input pixel_res_t want);
    directed.push_back('{ROW_BYTE, tga_rle_pkg::CFG_BPP, 32'h0, b, 1'b1, want});
  endtask

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    pixel_res_t want;
    pixel_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_red, out_green, out_blue, out_alpha, out_run_length, out_start_index,
              out_image_done};
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pixels_due.pop_front();
        results_checked++;
        if (got.red !== want.red)
          report_mismatch($sformatf("red %h, want %h", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %h, want %h", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
        if (got.run !== want.run)
          report_mismatch($sformatf("run_length %0d, want %0d", got.run, want.run));
        if (got.start !== want.start)
          report_mismatch($sformatf("start_index %0d, want %0d", got.start, want.start));
        if (got.done !== want.done)
          report_mismatch($sformatf("image_done %b, want %b", got.done, want.done));
      end
    end
  end

  initial begin
    logic [31:0] value;
    logic [31:0] room;
    int          len;
    int          sent;
    int          npix;
    int          size;
    bit          rep;
    logic [6:0]  cnt;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tga_rle_pkg::CFG_BPP;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    cur_bpp = tga_rle_pkg::BPP_RST;
    cur_rle = tga_rle_pkg::RLE_RST;
    cur_total = tga_rle_pkg::TOTAL_RST;
    hdr_due = 1'b1;
    pkt_repeat = 1'b0;
    pkt_count = '0;
    slot = '0;
    gathered = '0;
    decoded = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset settings, complete image, zero total, widest and narrowest
    // pixels, a repeat run, a clipped run and a raw packet cut at the last pixel
    add_byte(8'h11);
    add_byte(8'h22);
    add_pixel(8'h33, make_pixel(8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 32'd0, 1'b1));
    add_byte(8'hFF);
    add_cfg(tga_rle_pkg::CFG_TOTAL, 32'd0);
    add_byte(8'h55);
    add_cfg(tga_rle_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
    add_cfg(tga_rle_pkg::CFG_BPP, 32'd4);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_pixel(8'hFF, make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 8'd1, 32'd1, 1'b0));
    add_cfg(tga_rle_pkg::CFG_BPP, 32'd2);
    add_byte(8'hFF);
    add_pixel(8'hFF, make_pixel(8'hF8, 8'hF8, 8'hF8, 8'h80, 8'd1, 32'd2, 1'b0));
    add_cfg(tga_rle_pkg::CFG_RLE, 32'd1);
    add_byte(8'h85);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_cfg(tga_rle_pkg::CFG_TOTAL, 32'd11);
    add_byte(8'hFF);
    add_byte(8'hE0);
    add_pixel(8'h03, make_pixel(8'h00, 8'hF8, 8'h00, 8'h00, 8'd2, 32'd9, 1'b1));
    add_cfg(tga_rle_pkg::CFG_TOTAL, 32'd12);
    add_cfg(tga_rle_pkg::CFG_BPP, 32'd7);
    add_byte(8'h7F);
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(8'h03);
    add_pixel(8'h04, make_pixel(8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 32'd11, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i - 1].kind != ROW_CFG) begin
          drain_results();
          phases++;
        end
        cfg_write(directed[i].idx, directed[i].value);
      end else begin
        send_byte(directed[i].data, directed[i].typed, directed[i].want);
      end
    end

    // Random phases: new settings while idle, then mostly well-formed packets
    while (bytes_decoded < MIN_DECODED || results_checked + pixels_due.size() < MIN_RESULTS)
    begin
      drain_results();
      phases++;
      if ($urandom_range(0, 1) == 0) begin
        value = $urandom();
        value[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(2, 4));
        cfg_write(tga_rle_pkg::CFG_BPP, value);
      end
      if ($urandom_range(0, 2) == 0) begin
        value = $urandom();
        cfg_write(tga_rle_pkg::CFG_RLE, value);
      end
      // Mostly extend the image; sometimes lower it to or below the count, or open it wide
      case ($urandom_range(0, 9))
        0: begin
          room = (decoded < 32'd5) ? decoded : 32'd5;
          cfg_write(tga_rle_pkg::CFG_TOTAL, decoded - 32'($urandom_range(0, room)));
        end
        1:       cfg_write(tga_rle_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
        default: cfg_write(tga_rle_pkg::CFG_TOTAL, decoded + 32'($urandom_range(1, 60)));
      endcase

      len = $urandom_range(8, 48);
      sent = 0;
      while (sent < len) begin
        size = (cur_bpp < 3'd2) ? 2 : (cur_bpp > 3'd4) ? 4 : cur_bpp;
        if (!cur_rle || $urandom_range(0, 9) == 0) begin
          send_byte(pick_byte(), 1'b0, '0);
          sent++;
        end else begin
          rep = 1'($urandom_range(0, 1));
          cnt = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 5));
          send_byte({rep, cnt}, 1'b0, '0);
          sent++;
          npix = rep ? 1 : cnt + 1;
          // A packet may be cut short where the phase ends
          for (int p = 0; p < npix * size && sent < len; p++) begin
            send_byte(pick_byte(), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    // Wait out the last results and the pipeline
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d stream bytes (%0d decoded, rest dropped) over %0d setting phases;",
             bytes_sent, bytes_decoded, phases);
    $display("checked %0d pixel results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
